// ----- rtl/i2cm_pkg.sv -----
// Package for the I2C master byte engine: action codes, controller states
// and the packed command and response beat types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

	// Action codes carried by a command beat.
	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	// Bit position of the most significant data bit, and the bit count that
	// marks the acknowledge slot.
	localparam int unsigned BYTE_MSB = 7;
	localparam logic [3:0]  ACK_SLOT = 4'd8;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic       ack_bit;
		logic       sda_level;
	} cmd_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_level;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/i2c_master_byte_engine.sv -----
// I2C master byte engine, top level. A command beat is captured in the input
// register at acceptance; its result is taken into the response register when
// the sequencer fires, which waits while the response register is full and stalled.
// Throughput: one command beat per cycle while the response side does not stall.
// Reset: arst_n clears both stages and the sequencer, leaving both lines released.
// Depends on i2cm_pkg and i2cm_core.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine
	import i2cm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	// The command beat is first captured in an input register. The sequencer
	// processes it, and updates its state, in the cycle that the response
	// register can take the result: when it is empty or is being emptied.
	// The input register therefore refills in the same cycle, so a steady
	// stream of beats flows at one per cycle while downstream takes them.

	logic cmd_valid_s1;
	cmd_t cmd_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t res;
	logic fire;

	assign fire      = cmd_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = cmd_valid_s1 && !fire;

	i2cm_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire),
		.item  (cmd_s1),
		.res   (res)
	);

	// Input register: holds a beat until the sequencer has consumed it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Response register: a finished result waits here while the next beat is
	// already held in the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/i2cm_core.sv -----
// Bus sequencer of the I2C master: controller state registers and the
// next-state logic for one command beat. Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core
	import i2cm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire cmd_t item,
	output rsp_t      res
);

	op_t        op_q, op_d;
	logic [1:0] phase_q, phase_d;
	logic [3:0] count_q, count_d;
	logic [7:0] shift_q, shift_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       ack_q, ack_d;
	logic       done;
	logic [7:0] rbyte;
	logic       alev;

	// Next controller state.
	always_comb begin
		op_d = op_q;
		case (op_q)
			OP_IDLE: begin
				case (item.action)
					ACT_START: op_d = OP_START;
					ACT_STOP:  op_d = OP_STOP;
					ACT_WRITE: op_d = OP_WRITE;
					ACT_READ:  op_d = OP_READ;
					default:   op_d = OP_IDLE;
				endcase
			end
			OP_START, OP_STOP: begin
				if (item.action == ACT_TICK && phase_q == 2'd2) begin
					op_d = OP_IDLE;
				end
			end
			OP_WRITE, OP_READ: begin
				if (item.action == ACT_TICK && phase_q != 2'd0 && count_q >= ACK_SLOT) begin
					op_d = OP_IDLE;
				end
			end
			default: op_d = OP_IDLE;
		endcase
	end

	// Line drivers, shift register, counters and the result fields.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		shift_d = shift_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		done    = 1'b0;
		rbyte   = 8'd0;
		alev    = 1'b0;
		if (op_q == OP_IDLE) begin
			case (item.action)
				ACT_START: begin
					phase_d = 2'd0;
					scl_d   = 1'b0;
					sda_d   = 1'b0;
				end
				ACT_STOP: begin
					phase_d = 2'd0;
					sda_d   = 1'b1;
				end
				ACT_WRITE: begin
					phase_d = 2'd0;
					count_d = 4'd0;
					shift_d = item.data_byte;
					sda_d   = ~item.data_byte[BYTE_MSB];
				end
				ACT_READ: begin
					phase_d = 2'd0;
					count_d = 4'd0;
					shift_d = 8'd0;
					ack_d   = item.ack_bit;
					sda_d   = 1'b0;
				end
				default: begin
				end
			endcase
		end else if (item.action == ACT_TICK) begin
			if (op_q == OP_START || op_q == OP_STOP) begin
				case (phase_q)
					2'd0: begin
						if (op_q == OP_START) sda_d = 1'b1;
						else scl_d = 1'b0;
						phase_d = 2'd1;
					end
					2'd1: begin
						if (op_q == OP_START) scl_d = 1'b1;
						else sda_d = 1'b0;
						phase_d = 2'd2;
					end
					default: begin
						phase_d = 2'd0;
						done    = 1'b1;
					end
				endcase
			end else if (phase_q == 2'd0) begin
				scl_d   = 1'b0;
				phase_d = 2'd1;
			end else begin
				// Second half of a bit slot: sample, pull SCL and set up the next bit.
				scl_d   = 1'b1;
				phase_d = 2'd0;
				if (count_q >= ACK_SLOT) begin
					done    = 1'b1;
					count_d = 4'd0;
					if (op_q == OP_WRITE) begin
						ack_d = item.sda_level;
						alev  = item.sda_level;
					end else begin
						rbyte = shift_q;
					end
				end else begin
					count_d = count_q + 4'd1;
					if (op_q == OP_WRITE) begin
						shift_d = {shift_q[6:0], 1'b0};
						sda_d   = (count_d < ACK_SLOT) ? ~shift_d[BYTE_MSB] : 1'b0;
					end else begin
						shift_d = {shift_q[6:0], item.sda_level};
						sda_d   = (count_d < ACK_SLOT) ? 1'b0 : ~ack_q;
					end
				end
			end
		end
	end

	always_comb begin
		res.scl_drive_low = scl_d;
		res.sda_drive_low = sda_d;
		res.busy_res      = (op_d != OP_IDLE);
		res.done_res      = done;
		res.read_byte     = rbyte;
		res.ack_level     = alev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			phase_q <= 2'd0;
			count_q <= 4'd0;
			shift_q <= 8'd0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			ack_q   <= 1'b0;
		end else if (step) begin
			op_q    <= op_d;
			phase_q <= phase_d;
			count_q <= count_d;
			shift_q <= shift_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the I2C master byte engine: directed command
// table, then random command and tick beats checked against a bus predictor.
// Depends on i2cm_pkg and the i2c_master_byte_engine RTL.
`timescale 1ns / 1ps

module testbench
	import i2cm_pkg::*;
();

	// Action codes that the engine must ignore whatever its state.
	localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
	localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

	localparam int RAND_BEATS    = 980;      // random beats that move the bus
	localparam int STEADY_FROM   = 250;      // window with no idling on either side
	localparam int STEADY_TO     = 400;
	localparam int QUIET_AT      = 800;      // sender waits for the bus to drain here
	localparam int LONG_HOLD_AT  = 500;      // response beat after which the receiver holds off
	localparam int LONG_HOLD     = 90;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		cmd_t       beat;
		logic [4:0] reps;
		logic       typed;
		rsp_t       want;
	} plan_row_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Predictor state: the bus sequencer as the engine should hold it.
	op_t        bus_op;
	logic [1:0] q_phase;
	logic [3:0] bits_done;
	logic [7:0] shreg;
	logic       scl_dl;
	logic       sda_dl;
	logic       ack_hold;

	rsp_t       expected_rsp[$];
	plan_row_t  directed_plan[$];

	logic        steady = 1'b0;
	int          rx_wait = 0;
	int          rx_long = 0;
	int          rx_draw;
	int          checked = 0;
	int          fail_count = 0;
	int unsigned cycle_count = 0;
	int          beats_by_action[8];
	int          ignored_beats = 0;
	rsp_t        want_rsp;

	i2c_master_byte_engine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// One step of the bus: returns the response beat that the
	// engine should produce for this command beat.
	function automatic rsp_t bus_step(input cmd_t c);
		rsp_t r;
		r = '0;
		if (bus_op == OP_IDLE) begin
			case (c.action)
				ACT_START: begin
					bus_op = OP_START; q_phase = 2'd0; scl_dl = 1'b0; sda_dl = 1'b0;
				end
				ACT_STOP: begin
					bus_op = OP_STOP; q_phase = 2'd0; sda_dl = 1'b1;
				end
				ACT_WRITE: begin
					bus_op = OP_WRITE; q_phase = 2'd0; bits_done = 4'd0;
					shreg = c.data_byte;
					sda_dl = ~c.data_byte[BYTE_MSB];
				end
				ACT_READ: begin
					bus_op = OP_READ; q_phase = 2'd0; bits_done = 4'd0;
					shreg = 8'h00; ack_hold = c.ack_bit; sda_dl = 1'b0;
				end
				default: ;
			endcase
		end else if (c.action == ACT_TICK) begin
			if (bus_op == OP_START || bus_op == OP_STOP) begin
				if (q_phase == 2'd0) begin
					if (bus_op == OP_START) sda_dl = 1'b1; else scl_dl = 1'b0;
					q_phase = 2'd1;
				end else if (q_phase == 2'd1) begin
					if (bus_op == OP_START) scl_dl = 1'b1; else sda_dl = 1'b0;
					q_phase = 2'd2;
				end else begin
					q_phase = 2'd0; bus_op = OP_IDLE; r.done_res = 1'b1;
				end
			end else if (q_phase == 2'd0) begin
				// First half of a bit slot: release SCL.
				scl_dl = 1'b0;
				q_phase = 2'd1;
			end else begin
				// Second half: sample, pull SCL low and set up the next slot.
				scl_dl = 1'b1;
				q_phase = 2'd0;
				if (bits_done >= ACK_SLOT) begin
					if (bus_op == OP_WRITE) begin
						ack_hold = c.sda_level;
						r.ack_level = c.sda_level;
					end else begin
						r.read_byte = shreg;
					end
					r.done_res = 1'b1; bus_op = OP_IDLE; bits_done = 4'd0;
				end else if (bus_op == OP_WRITE) begin
					shreg = shreg << 1;
					bits_done = bits_done + 4'd1;
					sda_dl = (bits_done < ACK_SLOT) ? ~shreg[BYTE_MSB] : 1'b0;
				end else begin
					shreg = {shreg[BYTE_MSB-1:0], c.sda_level};
					bits_done = bits_done + 4'd1;
					sda_dl = (bits_done < ACK_SLOT) ? 1'b0 : ~ack_hold;
				end
			end
		end
		r.scl_drive_low = scl_dl;
		r.sda_drive_low = sda_dl;
		r.busy_res = (bus_op != OP_IDLE);
		return r;
	endfunction

	function automatic rsp_t bus_rsp(input logic scl, input logic sda, input logic busy,
			input logic done, input logic [7:0] rbyte, input logic alev);
		rsp_t r;
		r.scl_drive_low = scl;
		r.sda_drive_low = sda;
		r.busy_res = busy;
		r.done_res = done;
		r.read_byte = rbyte;
		r.ack_level = alev;
		return r;
	endfunction

	function automatic void add_row(input logic [2:0] act, input logic [7:0] data,
			input logic ack, input logic sda, input int reps, input logic typed,
			input rsp_t want);
		plan_row_t row;
		row.beat.action = act;
		row.beat.data_byte = data;
		row.beat.ack_bit = ack;
		row.beat.sda_level = sda;
		row.reps = reps[4:0];
		row.typed = typed;
		row.want = want;
		directed_plan.push_back(row);
	endfunction

	// Offers one command beat after a random gap and, once it is taken, records
	// the response that it should cause.
	task automatic push_beat(input cmd_t c, input logic typed, input rsp_t want);
		int gap;
		logic ignored;
		rsp_t pred;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		if (bus_op == OP_IDLE)
			ignored = !(c.action >= ACT_START && c.action <= ACT_READ);
		else
			ignored = (c.action != ACT_TICK);
		if (ignored)
			ignored_beats++;
		else
			beats_by_action[c.action]++;
		pred = bus_step(c);
		expected_rsp.push_back(typed ? want : pred);
	endtask

	task automatic note_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("Mismatch on response beat %0d, %s: expected %0h, got %0h",
				checked, name, want, got);
	endtask

	// Response side: checks every beat taken and draws the next hold-off.
	always @(posedge clk) begin
		if (rx_long > 0) begin
			rx_long <= rx_long - 1;
			rsp_stall <= (rx_long > 1);
		end else if (rsp_valid && !rsp_stall) begin
			checked++;
			if (expected_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("Response beat %0d arrived with nothing expected", checked);
			end else begin
				want_rsp = expected_rsp.pop_front();
				if (rsp.scl_drive_low !== want_rsp.scl_drive_low)
					note_field("scl_drive_low", 8'(want_rsp.scl_drive_low),
						8'(rsp.scl_drive_low));
				if (rsp.sda_drive_low !== want_rsp.sda_drive_low)
					note_field("sda_drive_low", 8'(want_rsp.sda_drive_low),
						8'(rsp.sda_drive_low));
				if (rsp.busy_res !== want_rsp.busy_res)
					note_field("busy_res", 8'(want_rsp.busy_res), 8'(rsp.busy_res));
				if (rsp.done_res !== want_rsp.done_res)
					note_field("done_res", 8'(want_rsp.done_res), 8'(rsp.done_res));
				if (rsp.read_byte !== want_rsp.read_byte)
					note_field("read_byte", want_rsp.read_byte, rsp.read_byte);
				if (rsp.ack_level !== want_rsp.ack_level)
					note_field("ack_level", 8'(want_rsp.ack_level), 8'(rsp.ack_level));
			end
			if (checked == LONG_HOLD_AT) begin
				// Hold off long enough for the engine to fill and stall its input.
				rx_long <= LONG_HOLD;
				rsp_stall <= 1'b1;
			end else begin
				rx_draw = steady ? 0 : $urandom_range(0, 3);
				rx_wait <= rx_draw;
				rsp_stall <= (rx_draw != 0);
			end
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			rsp_stall <= (rx_wait > 1);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d responses outstanding",
				cycle_count, expected_rsp.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int moving;
		int roll;
		logic counts;
		cmd_t c;
		plan_row_t row;

		bus_op = OP_IDLE;
		q_phase = 2'd0;
		bits_done = 4'd0;
		shreg = 8'h00;
		scl_dl = 1'b0;
		sda_dl = 1'b0;
		ack_hold = 1'b0;
		foreach (beats_by_action[k]) beats_by_action[k] = 0;

		// Idle behaviour and ignored codes, then each command in turn. Rows whose
		// response is obvious carry it; the rest rely on the predictor.
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			bus_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
		add_row(ACT_UNDEF_HI, 8'hFF, 1'b1, 1'b1, 1, 1'b1,
			bus_rsp(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
		add_row(ACT_START, 8'h00, 1'b0, 1'b0, 1, 1'b1,
			bus_rsp(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
		add_row(ACT_WRITE, 8'h00, 1'b1, 1'b0, 1, 1'b1,
			bus_rsp(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
		add_row(ACT_UNDEF_HI, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			bus_rsp(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b0, 2, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1,
			bus_rsp(1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0));
		add_row(ACT_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, 2, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			bus_rsp(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0));
		add_row(ACT_WRITE, 8'hFF, 1'b0, 1'b0, 1, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b0, 17, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			bus_rsp(1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1));
		add_row(ACT_READ, 8'h00, 1'b0, 1'b0, 1, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, 17, 1'b0, '0);
		add_row(ACT_TICK, 8'h00, 1'b0, 1'b1, 1, 1'b1,
			bus_rsp(1'b1, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			for (int n = 0; n < row.reps; n++)
				push_beat(row.beat, row.typed, row.want);
		end

		// Random part. An idle bus mostly gets a command and a busy one mostly
		// ticks, so whole transfers run with random data; the remainder is
		// stray ticks, commands dropped while busy and undefined codes.
		moving = 0;
		while (moving < RAND_BEATS) begin
			c.data_byte = 8'($urandom_range(0, 255));
			c.ack_bit = 1'($urandom_range(0, 1));
			c.sda_level = 1'($urandom_range(0, 1));
			roll = $urandom_range(0, 99);
			if (bus_op == OP_IDLE) begin
				if (roll < 88)
					c.action = 3'($urandom_range(ACT_START, ACT_READ));
				else if (roll < 94)
					c.action = ACT_TICK;
				else
					c.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
				counts = (c.action >= ACT_START && c.action <= ACT_READ);
			end else begin
				if (roll < 90)
					c.action = ACT_TICK;
				else if (roll < 95)
					c.action = 3'($urandom_range(ACT_START, ACT_READ));
				else
					c.action = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
				counts = (c.action == ACT_TICK);
			end
			if (counts)
				moving++;
			steady <= (moving >= STEADY_FROM && moving < STEADY_TO);
			if (counts && moving == QUIET_AT) begin
				// Let every outstanding response drain before going on.
				cmd_valid <= 1'b0;
				while (expected_rsp.size() != 0) @(posedge clk);
			end
			push_beat(c, 1'b0, '0);
		end

		cmd_valid <= 1'b0;
		steady <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d start, %0d stop, %0d write and %0d read commands, %0d ticks",
			beats_by_action[ACT_START], beats_by_action[ACT_STOP],
			beats_by_action[ACT_WRITE], beats_by_action[ACT_READ],
			beats_by_action[ACT_TICK]);
		$display("plus %0d ignored beats; %0d response beats checked, %0d failures",
			ignored_beats, checked, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_core.sv
rtl/i2c_master_byte_engine.sv
tb/sv/testbench.sv
